// File: hdl/cgct_pkg.sv
// shared constants for the call-graph count table
`timescale 1ns / 1ps

package cgct_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned USED_W  = 5;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic {
    KIND_CALL = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

endpackage

// File: hdl/call_graph_count_table.sv
// call-graph profiler: function address table and caller-by-callee count matrix
//
//  channel   dir  payload                                              role
//  s_axis    in   tuser: kind, caller_present                          call or read transaction
//                 tdata: caller_address, callee_address, row, column
//  m_axis    out  tdata: from_entry, to_entry, count, row_address,     one result per transaction
//                        entries_used, table_full_drop
//
// one transaction at a time; tready is high only while the sequencer is idle
// a call transaction walks the address table up to twice (callee, then caller) through
// one 32-bit comparator, each entry taking a table read and then a compare;
// a read transaction passes S_CNT_RD and S_CNT_WR before its result is valid in S_OUT;
// the count read-modify-write shares one 32-bit incrementer and one port pair on
// the count memory
// after reset the count memory is cleared one cell a cycle, all ENTRIES*ENTRIES cells,
// with tready low; a stalled result holds until m_axis_tready_i is high
`timescale 1ns / 1ps

module call_graph_count_table
  import cgct_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [31:0] caller_address, [63:32] callee_address, [67:64] row_index, [71:68] column_index
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [0] kind, [1] caller_present
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,

  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [3:0] from_entry, [7:4] to_entry, [39:8] count, [71:40] row_address,
  // [76:72] entries_used, [77] table_full_drop, [79:78] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CELLS  = ENTRIES * ENTRIES;
  localparam int unsigned CELL_W = $clog2(CELLS);

  // sequencer states
  typedef enum logic [9:0] {
    S_CLEAR    = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_CE_RD    = 10'b00_0000_0100,
    S_CE_CMP   = 10'b00_0000_1000,
    S_CR_START = 10'b00_0001_0000,
    S_CR_RD    = 10'b00_0010_0000,
    S_CR_CMP   = 10'b00_0100_0000,
    S_CNT_RD   = 10'b00_1000_0000,
    S_CNT_WR   = 10'b01_0000_0000,
    S_OUT      = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // memories
  logic [ADDR_W-1:0]  ent_mem [ENTRIES];
  logic [COUNT_W-1:0] cnt_mem [CELLS];

  logic [ADDR_W-1:0]  ent_rdata_q;
  logic [COUNT_W-1:0] cnt_rdata_q;

  logic               ent_we;
  logic [IDX_W-1:0]   ent_waddr;
  logic [IDX_W-1:0]   ent_raddr;
  logic               cnt_we;
  logic [CELL_W-1:0]  cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [CELL_W-1:0]  cell_addr;

  // control state
  logic [CNT_W-1:0]   used_q, used_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic [CELL_W-1:0]  clr_q, clr_d;

  // captured transaction
  logic               kind_q, kind_d;
  logic               present_q, present_d;
  logic [ADDR_W-1:0]  caller_q, caller_d;
  logic [ADDR_W-1:0]  callee_q, callee_d;
  logic [SLOT_W-1:0]  row_q, row_d;
  logic [SLOT_W-1:0]  col_q, col_d;
  logic               row_ok_q, row_ok_d;
  logic               col_ok_q, col_ok_d;

  // working slots
  logic [IDX_W-1:0]   from_q, from_d;
  logic [IDX_W-1:0]   to_q, to_d;

  // result register
  logic [SLOT_W-1:0]  out_from_q, out_from_d;
  logic [SLOT_W-1:0]  out_to_q, out_to_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;
  logic [ADDR_W-1:0]  out_raddr_q, out_raddr_d;
  logic               out_drop_q, out_drop_d;

  // shared compare and increment
  logic [ADDR_W-1:0]  key;
  logic               key_match;
  logic [COUNT_W-1:0] cnt_next;

  logic [ADDR_W-1:0]  in_caller;
  logic [ADDR_W-1:0]  in_callee;
  logic [SLOT_W-1:0]  in_row;
  logic [SLOT_W-1:0]  in_col;
  logic               s_accept;

  assign in_caller = s_axis_tdata_i[31:0];
  assign in_callee = s_axis_tdata_i[63:32];
  assign in_row    = s_axis_tdata_i[67:64];
  assign in_col    = s_axis_tdata_i[71:68];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign key       = (state_q == S_CE_CMP) ? callee_q : caller_q;
  assign key_match = (ent_rdata_q == key);
  assign cnt_next  = (cnt_rdata_q == COUNT_MAX) ? cnt_rdata_q : cnt_rdata_q + COUNT_W'(1);

  assign cell_addr = CELL_W'(from_q) * CELL_W'(ENTRIES) + CELL_W'(to_q);

  // table walk reads by pointer, otherwise the caller row
  assign ent_raddr = (state_q == S_CE_RD || state_q == S_CR_RD) ? ptr_q[IDX_W-1:0] : from_q;

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    ptr_d       = ptr_q;
    clr_d       = clr_q;
    kind_d      = kind_q;
    present_d   = present_q;
    caller_d    = caller_q;
    callee_d    = callee_q;
    row_d       = row_q;
    col_d       = col_q;
    row_ok_d    = row_ok_q;
    col_ok_d    = col_ok_q;
    from_d      = from_q;
    to_d        = to_q;
    out_from_d  = out_from_q;
    out_to_d    = out_to_q;
    out_count_d = out_count_q;
    out_raddr_d = out_raddr_q;
    out_drop_d  = out_drop_q;
    ent_we      = 1'b0;
    ent_waddr   = used_q[IDX_W-1:0];
    cnt_we      = 1'b0;
    cnt_waddr   = cell_addr;
    cnt_wdata   = cnt_next;

    unique case (state_q)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
        clr_d     = clr_q + CELL_W'(1);
        if (clr_q == CELL_W'(CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_accept) begin
          kind_d     = s_axis_tuser_i[0];
          present_d  = s_axis_tuser_i[1];
          caller_d   = in_caller;
          callee_d   = in_callee;
          row_d      = in_row;
          col_d      = in_col;
          out_drop_d = 1'b0;
          ptr_d      = '0;
          if (s_axis_tuser_i[0] == KIND_READ) begin
            row_ok_d = (32'(in_row) < ENTRIES);
            col_ok_d = (32'(in_col) < ENTRIES);
            from_d   = IDX_W'(in_row);
            to_d     = IDX_W'(in_col);
            state_d  = S_CNT_RD;
          end else begin
            row_ok_d = 1'b1;
            col_ok_d = 1'b1;
            to_d     = '0;
            // address zero is never registered and maps to slot 0
            state_d  = (in_callee == '0) ? S_CR_START : S_CE_RD;
          end
        end
      end

      S_CE_RD: begin
        if (ptr_q < used_q) begin
          state_d = S_CE_CMP;
        end else if (used_q >= CNT_W'(ENTRIES)) begin
          // table full: callee dropped, unknown address maps to slot 0
          out_drop_d = 1'b1;
          to_d       = '0;
          state_d    = S_CR_START;
        end else begin
          ent_we  = 1'b1;
          to_d    = used_q[IDX_W-1:0];
          used_d  = used_q + CNT_W'(1);
          state_d = S_CR_START;
        end
      end

      S_CE_CMP: begin
        if (key_match) begin
          to_d    = ptr_q[IDX_W-1:0];
          state_d = S_CR_START;
        end else begin
          ptr_d   = ptr_q + CNT_W'(1);
          state_d = S_CE_RD;
        end
      end

      S_CR_START: begin
        ptr_d  = '0;
        from_d = '0;
        if (!present_q) begin
          // no caller: no cell changes
          out_from_d  = '0;
          out_to_d    = SLOT_W'(to_q);
          out_count_d = '0;
          out_raddr_d = '0;
          state_d     = S_OUT;
        end else if (caller_q == '0) begin
          state_d = S_CNT_RD;
        end else begin
          state_d = S_CR_RD;
        end
      end

      S_CR_RD: begin
        if (ptr_q < used_q) begin
          state_d = S_CR_CMP;
        end else begin
          from_d  = '0;
          state_d = S_CNT_RD;
        end
      end

      S_CR_CMP: begin
        if (key_match) begin
          from_d  = ptr_q[IDX_W-1:0];
          state_d = S_CNT_RD;
        end else begin
          ptr_d   = ptr_q + CNT_W'(1);
          state_d = S_CR_RD;
        end
      end

      S_CNT_RD: begin
        // count cell and row address are read this cycle
        state_d = S_CNT_WR;
      end

      S_CNT_WR: begin
        // rows past the fill count read as empty
        out_raddr_d = (row_ok_q && (CNT_W'(from_q) < used_q)) ? ent_rdata_q : '0;
        if (kind_q == KIND_READ) begin
          out_from_d  = row_q;
          out_to_d    = col_q;
          out_count_d = (row_ok_q && col_ok_q) ? cnt_rdata_q : '0;
        end else begin
          cnt_we      = 1'b1;
          out_from_d  = SLOT_W'(from_q);
          out_to_d    = SLOT_W'(to_q);
          out_count_d = cnt_next;
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        if (m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      used_q  <= '0;
      ptr_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      ptr_q   <= ptr_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    present_q   <= present_d;
    caller_q    <= caller_d;
    callee_q    <= callee_d;
    row_q       <= row_d;
    col_q       <= col_d;
    row_ok_q    <= row_ok_d;
    col_ok_q    <= col_ok_d;
    from_q      <= from_d;
    to_q        <= to_d;
    out_from_q  <= out_from_d;
    out_to_q    <= out_to_d;
    out_count_q <= out_count_d;
    out_raddr_q <= out_raddr_d;
    out_drop_q  <= out_drop_d;
  end

  // address table: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= callee_q;
    end
    ent_rdata_q <= ent_mem[ent_raddr];
  end

  // count matrix: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_q <= cnt_mem[cell_addr];
  end

  // ------------------------------------------------------------------
  // result channel
  // ------------------------------------------------------------------
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tdata_o  = {2'b00, out_drop_q, USED_W'(used_q), out_raddr_q, out_count_q,
                            out_to_q, out_from_q};

endmodule
